// ----- design/sbsm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sbsm_pkg;

  // Memory selected by one bus access.
  typedef enum logic [2:0] {
    TGT_INVALID   = 3'd0,
    TGT_CHR_ROM   = 3'd1,
    TGT_CHR_RAM   = 3'd2,
    TGT_NAMETABLE = 3'd3,
    TGT_PRG_RAM   = 3'd4,
    TGT_PRG_ROM   = 3'd5,
    TGT_MAPPER    = 3'd6
  } target_t;

  // Nametable mirroring arrangements.
  typedef enum logic [1:0] {
    MIRROR_LOWER      = 2'd0,
    MIRROR_UPPER      = 2'd1,
    MIRROR_VERTICAL   = 2'd2,
    MIRROR_HORIZONTAL = 2'd3
  } mirror_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PRG_BANKS  = 2'd0;
  localparam logic [1:0] CFG_CHR_BANKS  = 2'd1;
  localparam logic [1:0] CFG_HEADER_VER = 2'd2;

  // Internal mapper register numbers, from address bits 14:13.
  localparam logic [1:0] MREG_CONTROL = 2'd0;
  localparam logic [1:0] MREG_CHR0    = 2'd1;
  localparam logic [1:0] MREG_CHR1    = 2'd2;
  localparam logic [1:0] MREG_PRG     = 2'd3;

  // Program banking modes.
  localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

  localparam logic [4:0] PRG_BANKS_RESET = 5'd2;
  localparam logic [4:0] CHR_BANKS_RESET = 5'd0;

  typedef struct packed {
    logic        opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } access_t;

  typedef struct packed {
    target_t     target;
    logic [17:0] phys_offset;
    logic        write_strobe;
  } result_t;

  // Banking state seen by the address translator.
  typedef struct packed {
    mirror_t    mirror_mode;
    logic       chr_rom;
    logic [4:0] chr_low_bank;
    logic [4:0] chr_high_bank;
    logic [3:0] prg_low_bank;
    logic [3:0] prg_high_bank;
    logic [2:0] load_count;
  } bank_state_t;

  // True when the next shifted bit completes the loader and commits a register.
  function automatic logic commit_due(input logic [2:0] count);
    logic [2:0] count_inc;
    count_inc = count + 3'd1;
    return (count_inc >= 3'd5);
  endfunction

endpackage

`default_nettype wire

// ----- design/serial_bank_switch_mapper_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Serial-loaded bank switching cartridge mapper.
// The access channel takes one bus access word per cycle while not stalled
// (read or write, 16-bit bus address, data byte); the result channel returns,
// for each access in order, the target memory, the byte offset inside it and
// a store strobe. Both channels use valid/ready.
// A word is held in an input register, translated against the current
// banking state and written to the result register. One word per cycle is
// sustained while the receiver keeps taking results; the only loop is the
// banking state, which is updated in the same cycle a word moves to the
// result register.
// When the receiver stalls, the result register holds its word and the
// input register absorbs one more access before access_ready drops.
// Reset clears both registers and returns the banking state to power-up
// values: horizontal mirroring, two program banks with the last one in the high
// slot, and pattern RAM. The configuration port is a plain write port that
// should be used only while no access is in flight.
module serial_bank_switch_mapper_unit
  import sbsm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       access_valid,
  output logic            access_ready,
  input  wire access_t    access,
  output logic            result_valid,
  input  wire logic       result_ready,
  output result_t         result,
  input  wire logic       cfg_write_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [4:0] cfg_data
);

  logic        stage_valid;
  access_t     stage_word;
  logic        stage_advance;
  bank_state_t bank_state;
  result_t     xlate_word;

  assign stage_advance = stage_valid && (!result_valid || result_ready);
  assign access_ready  = !stage_valid || stage_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= (access_valid && access_ready) || (stage_valid && !stage_advance);
    end
  end

  always_ff @(posedge clk) begin
    if (access_valid && access_ready) begin
      stage_word <= access;
    end
  end

  sbsm_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .step         (stage_advance),
    .acc          (stage_word),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .state        (bank_state)
  );

  sbsm_xlate u_xlate (
    .acc   (stage_word),
    .state (bank_state),
    .res   (xlate_word)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= stage_advance || (result_valid && !result_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance) begin
      result <= xlate_word;
    end
  end

  // Input side stalls only behind a full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !access_ready |-> (result_valid && !result_ready))
    else $error("access stalled without a result stall");

  // An unmapped access carries no offset and no strobe.
  a_invalid_quiet: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.target == TGT_INVALID) |->
      (result.phys_offset == 18'd0 && !result.write_strobe))
    else $error("unmapped access with offset or strobe");

  // Read-only memories are never strobed.
  a_rom_no_strobe: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.target == TGT_PRG_ROM || result.target == TGT_CHR_ROM)) |->
      !result.write_strobe)
    else $error("store strobe on a ROM target");

endmodule

`default_nettype wire

// ----- design/sbsm_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sbsm_regs
  import sbsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire access_t     acc,
  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data,
  output bank_state_t      state
);

  logic [4:0] prg_bank_count, prg_bank_count_next;
  logic [4:0] chr_bank_count, chr_bank_count_next;
  logic       header_vertical, header_vertical_next;
  logic [4:0] load_shift, load_shift_next;
  logic [2:0] load_count, load_count_next;
  mirror_t    mirror_mode, mirror_mode_next;
  logic [1:0] prg_mode, prg_mode_next;
  logic       chr_mode, chr_mode_next;
  logic [4:0] chr_low_bank, chr_low_bank_next;
  logic [4:0] chr_high_bank, chr_high_bank_next;
  logic [3:0] prg_low_bank, prg_low_bank_next;
  logic [3:0] prg_high_bank, prg_high_bank_next;

  logic [4:0] last_bank_wide;
  logic [3:0] last_bank;
  logic [4:0] cfg_last_wide;
  logic       reg_write;
  logic [4:0] shifted;
  logic [4:0] chr_value;
  logic [3:0] prg_even;
  logic [1:0] reg_sel;

  // Last program bank follows the configured bank count, wrapped to four bits.
  assign last_bank_wide = prg_bank_count - 5'd1;
  assign last_bank      = last_bank_wide[3:0];
  assign cfg_last_wide  = cfg_data - 5'd1;

  assign reg_write = step && acc.opcode && acc.bus_address[15];
  assign shifted   = {acc.write_data[0], load_shift[4:1]};
  assign reg_sel   = acc.bus_address[14:13];
  assign prg_even  = {shifted[3:1], 1'b0};

  // Bank 0 value for pattern space, narrowed when the ROM is small.
  always_comb begin
    chr_value = shifted;
    if (chr_bank_count <= 5'd1) begin
      chr_value = {4'd0, shifted[0]};
    end
    if (!chr_mode) begin
      chr_value[0] = 1'b0;
    end
  end

  // Loader, register commits and configuration writes.
  always_comb begin
    prg_bank_count_next  = prg_bank_count;
    chr_bank_count_next  = chr_bank_count;
    header_vertical_next = header_vertical;
    load_shift_next      = load_shift;
    load_count_next      = load_count;
    mirror_mode_next     = mirror_mode;
    prg_mode_next        = prg_mode;
    chr_mode_next        = chr_mode;
    chr_low_bank_next    = chr_low_bank;
    chr_high_bank_next   = chr_high_bank;
    prg_low_bank_next    = prg_low_bank;
    prg_high_bank_next   = prg_high_bank;

    if (reg_write) begin
      if (acc.write_data[7]) begin
        load_shift_next    = 5'd0;
        load_count_next    = 3'd0;
        prg_mode_next      = PRG_MODE_FIX_HIGH;
        prg_high_bank_next = last_bank;
      end else if (commit_due(load_count)) begin
        load_shift_next = 5'd0;
        load_count_next = 3'd0;
        case (reg_sel)
          MREG_CONTROL: begin
            mirror_mode_next = mirror_t'(shifted[1:0]);
            prg_mode_next    = shifted[3:2];
            chr_mode_next    = shifted[4];
            if (shifted[3:2] == PRG_MODE_FIX_LOW) begin
              prg_low_bank_next = 4'd0;
            end else if (shifted[3:2] == PRG_MODE_FIX_HIGH) begin
              prg_high_bank_next = last_bank;
            end
          end
          MREG_CHR0: begin
            chr_low_bank_next = chr_value;
            if (!chr_mode) begin
              chr_high_bank_next = chr_value + 5'd1;
            end
          end
          MREG_CHR1: begin
            if (chr_mode) begin
              chr_high_bank_next = shifted;
            end
          end
          default: begin
            if (prg_mode <= 2'd1) begin
              prg_low_bank_next  = prg_even;
              prg_high_bank_next = prg_even + 4'd1;
            end else if (prg_mode == PRG_MODE_FIX_LOW) begin
              prg_high_bank_next = shifted[3:0];
            end else begin
              prg_low_bank_next = shifted[3:0];
            end
          end
        endcase
      end else begin
        load_shift_next = shifted;
        load_count_next = load_count + 3'd1;
      end
    end

    // Configuration must be written only while the block is idle; the block itself does not enforce this.
    if (cfg_write_en) begin
      case (cfg_index)
        CFG_PRG_BANKS: begin
          prg_bank_count_next = cfg_data;
          prg_high_bank_next  = cfg_last_wide[3:0];
        end
        CFG_CHR_BANKS: begin
          chr_bank_count_next = cfg_data;
        end
        CFG_HEADER_VER: begin
          header_vertical_next = cfg_data[0];
          mirror_mode_next     = cfg_data[0] ? MIRROR_VERTICAL : MIRROR_HORIZONTAL;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count  <= PRG_BANKS_RESET;
      chr_bank_count  <= CHR_BANKS_RESET;
      header_vertical <= 1'b0;
      load_shift      <= 5'd0;
      load_count      <= 3'd0;
      mirror_mode     <= MIRROR_HORIZONTAL;
      prg_mode        <= 2'd0;
      chr_mode        <= 1'b0;
      chr_low_bank    <= 5'd0;
      chr_high_bank   <= 5'd0;
      prg_low_bank    <= 4'd0;
      prg_high_bank   <= PRG_BANKS_RESET[3:0] - 4'd1;
    end else begin
      prg_bank_count  <= prg_bank_count_next;
      chr_bank_count  <= chr_bank_count_next;
      header_vertical <= header_vertical_next;
      load_shift      <= load_shift_next;
      load_count      <= load_count_next;
      mirror_mode     <= mirror_mode_next;
      prg_mode        <= prg_mode_next;
      chr_mode        <= chr_mode_next;
      chr_low_bank    <= chr_low_bank_next;
      chr_high_bank   <= chr_high_bank_next;
      prg_low_bank    <= prg_low_bank_next;
      prg_high_bank   <= prg_high_bank_next;
    end
  end

  // The unused header bit is kept so that a later reload sees the same value.
  assign state.mirror_mode   = mirror_mode;
  assign state.chr_rom       = (chr_bank_count != 5'd0);
  assign state.chr_low_bank  = chr_low_bank;
  assign state.chr_high_bank = chr_high_bank;
  assign state.prg_low_bank  = prg_low_bank;
  assign state.prg_high_bank = prg_high_bank;
  assign state.load_count    = load_count;

  // The loader never holds more than four bits between commits.
  a_load_count_bound: assert property (@(posedge clk) disable iff (rst)
    load_count <= 3'd4)
    else $error("loader count beyond four");

  // A clearing write leaves the loader empty with the last bank fixed high.
  a_clear_write: assert property (@(posedge clk) disable iff (rst)
    (reg_write && acc.write_data[7] && !cfg_write_en) |=>
      (load_count == 3'd0 && prg_mode == PRG_MODE_FIX_HIGH))
    else $error("loader clear did not take effect");

endmodule

`default_nettype wire

// ----- design/sbsm_xlate.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sbsm_xlate
  import sbsm_pkg::*;
(
  input  wire access_t     acc,
  input  wire bank_state_t state,
  output result_t          res
);

  logic [15:0] addr;
  logic [4:0]  chr_bank;
  logic [3:0]  prg_bank;
  logic [10:0] nt_offset;

  assign addr     = acc.bus_address;
  assign chr_bank = addr[12] ? state.chr_high_bank : state.chr_low_bank;
  assign prg_bank = addr[14] ? state.prg_high_bank : state.prg_low_bank;

  // Nametable offset within the 2 KB of console RAM.
  always_comb begin
    case (state.mirror_mode)
      MIRROR_LOWER:    nt_offset = {1'b0, addr[9:0]};
      MIRROR_UPPER:    nt_offset = {1'b1, addr[9:0]};
      MIRROR_VERTICAL: nt_offset = addr[10:0];
      default:         nt_offset = {addr[11], addr[9:0]};
    endcase
  end

  // Address decode into target memory, offset and store strobe.
  always_comb begin
    res.target       = TGT_INVALID;
    res.phys_offset  = 18'd0;
    res.write_strobe = 1'b0;
    if (addr[15]) begin
      if (acc.opcode) begin
        res.target       = TGT_MAPPER;
        res.phys_offset  = {16'd0, addr[14:13]};
        res.write_strobe = !acc.write_data[7] && commit_due(state.load_count);
      end else begin
        res.target      = TGT_PRG_ROM;
        res.phys_offset = {prg_bank, addr[13:0]};
      end
    end else begin
      case (addr[14:13])
        2'b00: begin
          res.phys_offset = {1'b0, chr_bank, addr[11:0]};
          if (state.chr_rom) begin
            res.target = TGT_CHR_ROM;
          end else begin
            res.target       = TGT_CHR_RAM;
            res.write_strobe = acc.opcode;
          end
        end
        2'b01: begin
          if (!addr[12]) begin
            res.target       = TGT_NAMETABLE;
            res.phys_offset  = {7'd0, nt_offset};
            res.write_strobe = acc.opcode;
          end
        end
        2'b11: begin
          res.target       = TGT_PRG_RAM;
          res.phys_offset  = {5'd0, addr[12:0]};
          res.write_strobe = acc.opcode;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sim/sbsm_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels and the configuration port of the mapper, keeps its
// own copy of the banking state, and compares every result word with the
// translation expected for the oldest outstanding access word.
module sbsm_checker
  import sbsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       access_valid,
  input  logic       access_ready,
  input  access_t    access,
  input  logic       result_valid,
  input  logic       result_ready,
  input  result_t    result,
  input  logic       cfg_write_en,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  output int         pending,
  output int         errors
);

  // Configuration copy.
  logic [4:0] prg_banks;
  logic [4:0] chr_banks;
  logic       hdr_vertical;

  // Banking state copy.
  logic [4:0] load_shift;
  logic [2:0] load_count;
  mirror_t    mirror_mode;
  logic [1:0] prg_mode;
  logic       chr_mode;
  logic [4:0] chr_low;
  logic [4:0] chr_high;
  logic [3:0] prg_low;
  logic [3:0] prg_high;

  result_t expected_results[$];

  initial begin
    pending = 0;
    errors  = 0;
  end

  function automatic logic [3:0] last_prg_bank(input logic [4:0] banks);
    logic [4:0] last;
    last = banks - 5'd1;
    return last[3:0];
  endfunction

  function automatic mirror_t header_mirror(input logic vertical);
    return vertical ? MIRROR_VERTICAL : MIRROR_HORIZONTAL;
  endfunction

  // Applies a fully loaded 5-bit value to the register picked by the address.
  task automatic commit_loaded(input logic [1:0] reg_num, input logic [4:0] v);
    logic [4:0] b;
    logic [3:0] p;
    b = v;
    p = v[3:0];
    case (reg_num)
      MREG_CONTROL: begin
        mirror_mode = mirror_t'(v[1:0]);
        prg_mode    = v[3:2];
        chr_mode    = v[4];
        if (prg_mode == PRG_MODE_FIX_LOW) begin
          prg_low = 4'd0;
        end else if (prg_mode == PRG_MODE_FIX_HIGH) begin
          prg_high = last_prg_bank(prg_banks);
        end
      end
      MREG_CHR0: begin
        if (chr_banks <= 5'd1) begin
          b = b & 5'd1;
        end
        if (!chr_mode) begin
          b[0]     = 1'b0;
          chr_low  = b;
          chr_high = b + 5'd1;
        end else begin
          chr_low = b;
        end
      end
      MREG_CHR1: begin
        if (chr_mode) begin
          chr_high = v;
        end
      end
      default: begin
        if (prg_mode <= 2'd1) begin
          prg_low  = {p[3:1], 1'b0};
          prg_high = {p[3:1], 1'b0} + 4'd1;
        end else if (prg_mode == PRG_MODE_FIX_LOW) begin
          prg_high = p;
        end else begin
          prg_low = p;
        end
      end
    endcase
  endtask

  // Translates one bus access and advances the serial loader.
  task automatic translate_access(input access_t a, output result_t r);
    logic [15:0] addr;
    logic [11:0] nt;
    logic [4:0]  cbank;
    logic [3:0]  pbank;
    addr           = a.bus_address;
    nt             = addr[11:0];
    r.target       = TGT_INVALID;
    r.phys_offset  = '0;
    r.write_strobe = 1'b0;
    if (addr < 16'h2000) begin
      cbank         = addr[12] ? chr_high : chr_low;
      r.phys_offset = {1'b0, cbank, addr[11:0]};
      if (chr_banks == 5'd0) begin
        r.target       = TGT_CHR_RAM;
        r.write_strobe = a.opcode;
      end else begin
        r.target = TGT_CHR_ROM;
      end
    end else if (addr < 16'h3000) begin
      r.target       = TGT_NAMETABLE;
      r.write_strobe = a.opcode;
      case (mirror_mode)
        MIRROR_LOWER:    r.phys_offset = {8'd0, nt[9:0]};
        MIRROR_UPPER:    r.phys_offset = {8'd1, nt[9:0]};
        MIRROR_VERTICAL: r.phys_offset = {7'd0, nt[10:0]};
        default:         r.phys_offset = {7'd0, nt[11], nt[9:0]};
      endcase
    end else if (addr >= 16'h6000 && addr < 16'h8000) begin
      r.target       = TGT_PRG_RAM;
      r.phys_offset  = {5'd0, addr[12:0]};
      r.write_strobe = a.opcode;
    end else if (addr[15] && !a.opcode) begin
      pbank         = addr[14] ? prg_high : prg_low;
      r.target      = TGT_PRG_ROM;
      r.phys_offset = {pbank, addr[13:0]};
    end else if (addr[15]) begin
      r.target      = TGT_MAPPER;
      r.phys_offset = {16'd0, addr[14:13]};
      if (a.write_data[7]) begin
        load_shift = '0;
        load_count = '0;
        prg_mode   = PRG_MODE_FIX_HIGH;
        prg_high   = last_prg_bank(prg_banks);
      end else begin
        load_shift = {a.write_data[0], load_shift[4:1]};
        load_count = load_count + 3'd1;
        if (load_count >= 3'd5) begin
          commit_loaded(addr[14:13], load_shift);
          load_shift     = '0;
          load_count     = '0;
          r.write_strobe = 1'b1;
        end
      end
    end
  endtask

  // Reset, result comparison, prediction and configuration tracking.
  always @(posedge clk) begin : track
    result_t predicted;
    result_t oldest;
    if (rst) begin
      prg_banks    = PRG_BANKS_RESET;
      chr_banks    = CHR_BANKS_RESET;
      hdr_vertical = 1'b0;
      load_shift   = '0;
      load_count   = '0;
      mirror_mode  = header_mirror(1'b0);
      prg_mode     = 2'd0;
      chr_mode     = 1'b0;
      chr_low      = '0;
      chr_high     = '0;
      prg_low      = '0;
      prg_high     = last_prg_bank(PRG_BANKS_RESET);
      expected_results.delete();
    end else begin
      // The result leaving this edge belongs to an access accepted earlier.
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with no access outstanding, actual %0d/%0h/%0b",
                   $time, result.target, result.phys_offset, result.write_strobe);
          errors++;
        end else begin
          oldest = expected_results.pop_front();
          if (result.target !== oldest.target) begin
            $display("%0t: target mismatch, expected %0d, actual %0d",
                     $time, oldest.target, result.target);
            errors++;
          end
          if (result.phys_offset !== oldest.phys_offset) begin
            $display("%0t: phys_offset mismatch, expected %0h, actual %0h",
                     $time, oldest.phys_offset, result.phys_offset);
            errors++;
          end
          if (result.write_strobe !== oldest.write_strobe) begin
            $display("%0t: write_strobe mismatch, expected %0b, actual %0b",
                     $time, oldest.write_strobe, result.write_strobe);
            errors++;
          end
        end
      end
      if (access_valid && access_ready) begin
        translate_access(access, predicted);
        expected_results.push_back(predicted);
      end
      // Configuration writes only arrive while the mapper is idle.
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_PRG_BANKS: begin
            prg_banks = cfg_data;
            prg_high  = last_prg_bank(cfg_data);
          end
          CFG_CHR_BANKS: chr_banks = cfg_data;
          CFG_HEADER_VER: begin
            hdr_vertical = cfg_data[0];
            mirror_mode  = header_mirror(cfg_data[0]);
          end
          default: ;
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- sim/tb_serial_bank_switch_mapper_unit.sv -----
`timescale 1ns / 1ps

module tb_serial_bank_switch_mapper_unit;
  import sbsm_pkg::*;

  localparam int         LIMIT_CYCLES   = 600000;
  localparam int         PHASES         = 8;
  localparam int         WORDS_PER_PH   = 232;
  localparam logic [1:0] CFG_SPARE      = 2'd3;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       access_valid = 1'b0;
  logic       access_ready;
  access_t    access       = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  result_t    result;
  logic       cfg_write_en = 1'b0;
  logic [1:0] cfg_index    = '0;
  logic [4:0] cfg_data     = '0;

  int pending;
  int errors;
  int cycles    = 0;
  int sent      = 0;
  int idle_pct  = 0;
  int stall_pct = 0;

  serial_bank_switch_mapper_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .access_valid (access_valid),
    .access_ready (access_ready),
    .access       (access),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  sbsm_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .access_valid (access_valid),
    .access_ready (access_ready),
    .access       (access),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .errors       (errors)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Offers one access word, with random idle cycles ahead of it.
  task automatic send_access(input access_t a);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      access_valid <= 1'b0;
      @(negedge clk);
    end
    access_valid <= 1'b1;
    access       <= a;
    @(posedge clk);
    while (!access_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_fields(input logic op, input logic [15:0] addr, input logic [7:0] data);
    access_t a;
    a.opcode      = op;
    a.bus_address = addr;
    a.write_data  = data;
    send_access(a);
  endtask

  // Address weighted over the regions of the bus map.
  function automatic logic [15:0] pick_address();
    logic [15:0] addr;
    addr = 16'($urandom);
    case ($urandom_range(5))
      0: addr = {3'b000, addr[12:0]};
      1: addr = {4'b0010, addr[11:0]};
      2: addr = 16'h3000 + 16'($urandom_range(16'h2FFF));
      3: addr = {3'b011, addr[12:0]};
      4: addr = {1'b1, addr[14:0]};
      default: ;
    endcase
    return addr;
  endfunction

  // Five serial writes that load one mapper register, least significant bit
  // first; reads may be scattered in between since they leave the loader alone.
  task automatic shift_in_register(input logic [1:0] reg_num, input logic [4:0] v,
                                   input bit scatter);
    logic [12:0] low_bits;
    for (int i = 0; i < 5; i++) begin
      low_bits = scatter ? 13'($urandom) : 13'd0;
      send_fields(1'b1, {1'b1, reg_num, low_bits},
                  {1'b0, scatter ? 6'($urandom) : 6'd0, v[i]});
      if (scatter && $urandom_range(99) < 20) begin
        send_fields(1'b0, pick_address(), 8'($urandom));
      end
    end
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [4:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Stops offering words and lets the pipeline empty out.
  task automatic drain();
    @(negedge clk);
    access_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Bank counts and mirroring for each phase, extremes first.
  task automatic apply_phase_settings(input int ph);
    logic [4:0] prg;
    logic [4:0] chr;
    logic       vert;
    prg  = 5'($urandom_range(16, 1));
    chr  = 5'($urandom_range(16, 0));
    vert = 1'($urandom);
    case (ph)
      1: begin prg = 5'd16; chr = 5'd16; vert = 1'b1; end
      2: begin prg = 5'd1;  chr = 5'd1;  vert = 1'b0; end
      3: begin prg = 5'd1;  chr = 5'd0;  vert = 1'b1; end
      4: begin prg = 5'd0;  chr = 5'd31; vert = 1'b0; end
      5: begin prg = 5'd17; chr = 5'd2;  vert = 1'b1; end
      default: ;
    endcase
    write_cfg(CFG_PRG_BANKS, prg);
    write_cfg(CFG_CHR_BANKS, chr);
    write_cfg(CFG_HEADER_VER, {4'($urandom), vert});
    if (ph == PHASES - 1) begin
      write_cfg(CFG_SPARE, 5'($urandom));
    end
  endtask

  initial begin
    int kind;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed words at the power-up banking state.
    send_fields(1'b0, 16'h0000, 8'h00);
    send_fields(1'b1, 16'h1FFF, 8'hFF);
    send_fields(1'b1, 16'h2FFF, 8'h5A);
    send_fields(1'b0, 16'h3000, 8'h00);
    send_fields(1'b1, 16'h5FFF, 8'hAA);
    send_fields(1'b1, 16'h7FFF, 8'h01);
    send_fields(1'b0, 16'hFFFF, 8'h00);
    send_fields(1'b1, 16'h8000, 8'h80);
    // Control: 4 KB pattern mode, low program bank fixed, one-screen lower.
    shift_in_register(MREG_CONTROL, 5'h18, 1'b0);
    // Program bank with bit 4 set, which must be dropped.
    shift_in_register(MREG_PRG, 5'h1F, 1'b0);
    send_fields(1'b0, 16'h8000, 8'h00);
    send_fields(1'b0, 16'hC000, 8'h00);
    send_fields(1'b0, 16'h1000, 8'h00);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        drain();
        apply_phase_settings(ph);
      end
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      while (sent < (ph + 1) * WORDS_PER_PH) begin
        kind = $urandom_range(99);
        if (kind < 45) begin
          shift_in_register(2'($urandom), 5'($urandom), 1'b1);
        end else if (kind < 80) begin
          access_t a;
          a.bus_address = pick_address();
          a.opcode      = a.bus_address[15] ? 1'b0 : 1'($urandom);
          a.write_data  = 8'($urandom);
          send_access(a);
        end else if (kind < 90) begin
          send_fields(1'b1, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
        end else begin
          send_fields(1'($urandom), 16'($urandom), 8'($urandom));
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- serial_bank_switch_mapper_unit.f -----
design/sbsm_pkg.sv
design/sbsm_regs.sv
design/sbsm_xlate.sv
design/serial_bank_switch_mapper_unit.sv
sim/sbsm_checker.sv
sim/tb_serial_bank_switch_mapper_unit.sv
